>>> design/tile_residency_lru_tracker_unit_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef TILE_RESIDENCY_LRU_TRACKER_UNIT_MACROS_SVH
`define TILE_RESIDENCY_LRU_TRACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/trlt_pkg.sv
`default_nettype none

package trlt_pkg;

    localparam int TILE_IDX_W = 16;
    localparam int LAT_W      = 8;
    localparam int LON_W      = 9;
    localparam int TS_W       = 3;
    localparam int RES_W      = 4;

    localparam logic [1:0] FN_DECLARE  = 2'd0;
    localparam logic [1:0] FN_QUERY    = 2'd1;
    localparam logic [1:0] FN_COMPLETE = 2'd2;
    localparam logic [1:0] FN_UNUSED   = 2'd3;

    localparam logic [TS_W-1:0] TS_UNKNOWN  = 3'd0;
    localparam logic [TS_W-1:0] TS_IDLE     = 3'd1;
    localparam logic [TS_W-1:0] TS_PENDING  = 3'd2;
    localparam logic [TS_W-1:0] TS_RESIDENT = 3'd3;
    localparam logic [TS_W-1:0] TS_FAILED   = 3'd4;

    localparam logic [RES_W-1:0] ST_DECLARED  = 4'd0;
    localparam logic [RES_W-1:0] ST_ABSENT    = 4'd1;
    localparam logic [RES_W-1:0] ST_HIT       = 4'd2;
    localparam logic [RES_W-1:0] ST_REQUESTED = 4'd3;
    localparam logic [RES_W-1:0] ST_PENDING   = 4'd4;
    localparam logic [RES_W-1:0] ST_FAILED    = 4'd5;
    localparam logic [RES_W-1:0] ST_INSTALLED = 4'd6;
    localparam logic [RES_W-1:0] ST_FAIL_REC  = 4'd7;
    localparam logic [RES_W-1:0] ST_IGNORED   = 4'd8;

    localparam logic signed [LAT_W-1:0] LAT_MIN = -8'sd90;
    localparam logic signed [LAT_W-1:0] LAT_MAX = 8'sd89;
    localparam logic signed [LON_W-1:0] LON_MIN = -9'sd180;
    localparam logic signed [LON_W-1:0] LON_MAX = 9'sd179;
    localparam logic [9:0]  LAT_OFS  = 10'd90;
    localparam logic [10:0] LON_OFS  = 11'd180;
    localparam logic [TILE_IDX_W-1:0] LON_SPAN = 16'd360;

    typedef struct packed {
        logic hit;
        logic install;
    } t_rec_cmd;

    typedef struct packed {
        logic [TILE_IDX_W-1:0]   idx;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_rec_ent;

    typedef struct packed {
        logic     full;
        t_rec_ent victim;
    } t_rec_info;

endpackage

`default_nettype wire

>>> design/tile_residency_lru_tracker_unit.sv
// Tile residency tracker with LRU replacement. Each input item names a one-degree tile by its
// south-west corner and a function (declare, query, load completion); each item yields exactly
// one result item with a status and, for an install that overflows capacity, the evicted tile.
// Tile states live in a single-port-write status table of STATUS_DEPTH entries, and the recency
// order of up to MAX_RESIDENT resident tiles lives in a register list searched in parallel.
// An item first reads the status table, then decides, writes back and updates the list; that
// step waits while the previous result is still held and not taken. An install that evicts then
// writes the victim's state in a separate state, since the status table has one write port. After
// reset the table is cleared one entry per cycle, so o_in_ready stays low until all of it is clear.
// A finished result waits in an output register, and the next item is accepted while it waits.
`default_nettype none

module tile_residency_lru_tracker_unit #(
    parameter int MAX_RESIDENT = 12,
    parameter int STATUS_DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_func,
    input  wire logic signed [7:0]        i_tile_lat,
    input  wire logic signed [8:0]        i_tile_lon,
    input  wire logic                     i_load_ok,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [3:0]                    o_status,
    output logic                          o_evict_valid,
    output logic signed [7:0]             o_evict_lat,
    output logic signed [8:0]             o_evict_lon
);

    localparam int AW = $clog2(STATUS_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_EVICT = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [AW-1:0]                       r_clr_addr;
    logic [1:0]                          r_func;
    logic signed [7:0]                   r_lat;
    logic signed [8:0]                   r_lon;
    logic                                r_ok;
    logic                                r_tile_ok;
    logic [trlt_pkg::TILE_IDX_W-1:0]     r_idx;
    logic [trlt_pkg::TILE_IDX_W-1:0]     r_victim_idx;
    logic                                r_out_valid;
    logic [3:0]                          r_status;
    logic                                r_evict_valid;
    logic signed [7:0]                   r_evict_lat;
    logic signed [8:0]                   r_evict_lon;

    logic                                w_in_fire;
    logic                                w_tile_ok;
    logic [9:0]                          w_lat_sum;
    logic [10:0]                         w_lon_sum;
    logic [trlt_pkg::TILE_IDX_W-1:0]     w_idx;
    logic                                w_step;
    logic [trlt_pkg::TS_W-1:0]           w_ts;
    logic [3:0]                          w_res;
    logic                                w_upd;
    logic [trlt_pkg::TS_W-1:0]           w_upd_ts;
    logic                                w_evict;
    logic                                w_ram_we;
    logic [AW-1:0]                       w_ram_waddr;
    logic [trlt_pkg::TS_W-1:0]           w_ram_wdata;
    logic [AW-1:0]                       w_ram_raddr;
    trlt_pkg::t_rec_cmd                  w_rec_cmd;
    trlt_pkg::t_rec_ent                  w_rec_ent;
    trlt_pkg::t_rec_info                 w_rec_info;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_tile_ok = (i_func != trlt_pkg::FN_UNUSED)
        && (i_tile_lat >= trlt_pkg::LAT_MIN) && (i_tile_lat <= trlt_pkg::LAT_MAX)
        && (i_tile_lon >= trlt_pkg::LON_MIN) && (i_tile_lon <= trlt_pkg::LON_MAX);

    assign w_lat_sum = {{2{i_tile_lat[7]}}, i_tile_lat} + trlt_pkg::LAT_OFS;
    assign w_lon_sum = {{2{i_tile_lon[8]}}, i_tile_lon} + trlt_pkg::LON_OFS;
    assign w_idx     = ({8'd0, w_lat_sum[7:0]} * trlt_pkg::LON_SPAN) + {7'd0, w_lon_sum[8:0]};

    assign w_step = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_res    = trlt_pkg::ST_IGNORED;
        w_upd    = 1'b0;
        w_upd_ts = trlt_pkg::TS_UNKNOWN;
        w_evict  = 1'b0;
        w_rec_cmd = '0;
        if (r_tile_ok) begin
            case (r_func)
                trlt_pkg::FN_DECLARE: begin
                    w_res = trlt_pkg::ST_DECLARED;
                    if (w_ts == trlt_pkg::TS_UNKNOWN) begin
                        w_upd    = 1'b1;
                        w_upd_ts = trlt_pkg::TS_IDLE;
                    end
                end
                trlt_pkg::FN_QUERY: begin
                    case (w_ts)
                        trlt_pkg::TS_RESIDENT: begin
                            w_res         = trlt_pkg::ST_HIT;
                            w_rec_cmd.hit = 1'b1;
                        end
                        trlt_pkg::TS_FAILED: begin
                            w_res = trlt_pkg::ST_FAILED;
                        end
                        trlt_pkg::TS_IDLE: begin
                            w_res    = trlt_pkg::ST_REQUESTED;
                            w_upd    = 1'b1;
                            w_upd_ts = trlt_pkg::TS_PENDING;
                        end
                        trlt_pkg::TS_PENDING: begin
                            w_res = trlt_pkg::ST_PENDING;
                        end
                        default: begin
                            w_res = trlt_pkg::ST_ABSENT;
                        end
                    endcase
                end
                trlt_pkg::FN_COMPLETE: begin
                    if (w_ts == trlt_pkg::TS_PENDING) begin
                        w_upd = 1'b1;
                        if (!r_ok) begin
                            w_res    = trlt_pkg::ST_FAIL_REC;
                            w_upd_ts = trlt_pkg::TS_FAILED;
                        end else begin
                            w_res             = trlt_pkg::ST_INSTALLED;
                            w_upd_ts          = trlt_pkg::TS_RESIDENT;
                            w_rec_cmd.install = 1'b1;
                            w_evict           = w_rec_info.full;
                        end
                    end
                end
                default: begin
                    w_res = trlt_pkg::ST_IGNORED;
                end
            endcase
        end
        if (!w_step) begin
            w_rec_cmd = '0;
        end
    end

    assign w_rec_ent = {r_idx, r_lat, r_lon};

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = AW'(r_idx);
        w_ram_wdata = w_upd_ts;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = trlt_pkg::TS_UNKNOWN;
            end
            S_LOOK: begin
                w_ram_we = w_step && w_upd;
            end
            S_EVICT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = AW'(r_victim_idx);
                w_ram_wdata = trlt_pkg::TS_IDLE;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    assign w_ram_raddr = (r_state == S_IDLE) ? AW'(w_idx) : AW'(r_idx);

    trlt_ram #(
        .WIDTH (trlt_pkg::TS_W),
        .DEPTH (STATUS_DEPTH)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ts)
    );

    trlt_recency #(
        .MAX_RESIDENT (MAX_RESIDENT)
    ) u_recency (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rec_cmd),
        .i_ent   (w_rec_ent),
        .o_info  (w_rec_info)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(STATUS_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_step) begin
                    n_state = w_evict ? S_EVICT : S_IDLE;
                end
            end
            S_EVICT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_func    <= i_func;
            r_lat     <= i_tile_lat;
            r_lon     <= i_tile_lon;
            r_ok      <= i_load_ok;
            r_tile_ok <= w_tile_ok;
            r_idx     <= w_idx;
        end
        if (w_step) begin
            r_victim_idx  <= w_rec_info.victim.idx;
            r_status      <= w_res;
            r_evict_valid <= w_evict;
            r_evict_lat   <= w_evict ? w_rec_info.victim.lat : 8'sd0;
            r_evict_lon   <= w_evict ? w_rec_info.victim.lon : 9'sd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_evict_valid = r_evict_valid;
    assign o_evict_lat   = r_evict_lat;
    assign o_evict_lon   = r_evict_lon;

`include "tile_residency_lru_tracker_unit_macros.svh"

    `TRLT_ASSERT_SAME(a_evict_on_install, o_out_valid && o_evict_valid, o_status == trlt_pkg::ST_INSTALLED, "eviction reported without an install")
    `TRLT_ASSERT_SAME(a_evict_after_result, r_state == S_EVICT, r_out_valid, "victim write without a posted result")
    `TRLT_ASSERT_NEXT(a_evict_one_cycle, r_state == S_EVICT, r_state == S_IDLE, "victim write did not finish in one cycle")

endmodule

`default_nettype wire

>>> design/trlt_ram.sv
`default_nettype none

module trlt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/trlt_recency.sv
`default_nettype none

module trlt_recency #(
    parameter int MAX_RESIDENT = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire trlt_pkg::t_rec_cmd   i_cmd,
    input  wire trlt_pkg::t_rec_ent   i_ent,
    output trlt_pkg::t_rec_info       o_info
);

    localparam int CW = $clog2(MAX_RESIDENT + 1);

    trlt_pkg::t_rec_ent        r_ent [MAX_RESIDENT];
    logic [CW-1:0]             r_count;
    logic [MAX_RESIDENT-1:0]   w_match;
    logic [MAX_RESIDENT-1:0]   w_shift;
    logic                      w_full;

    always_comb begin
        for (int i = 0; i < MAX_RESIDENT; i++) begin
            w_match[i] = (CW'(i) < r_count) && (r_ent[i].idx == i_ent.idx);
        end
        for (int i = 0; i < MAX_RESIDENT; i++) begin
            w_shift[i] = |(w_match >> i);
        end
    end

    assign w_full = (r_count == CW'(MAX_RESIDENT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit || i_cmd.install) begin
            r_ent[0] <= i_ent;
            for (int i = 1; i < MAX_RESIDENT; i++) begin
                if (i_cmd.install || w_shift[i]) begin
                    r_ent[i] <= r_ent[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.install && !w_full) begin
            r_count <= r_count + CW'(1);
        end
    end

    assign o_info.full   = w_full;
    assign o_info.victim = r_ent[MAX_RESIDENT-1];

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_RES       = 12;
    localparam int TILE_COUNT    = 65536;
    localparam int POOL_SIZE     = 24;
    localparam int RANDOM_TARGET = 1180;
    localparam int IDLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [3:0]        status;
        logic              ev_valid;
        logic signed [7:0] ev_lat;
        logic signed [8:0] ev_lon;
    } t_tile_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_func;
    logic signed [7:0] i_tile_lat;
    logic signed [8:0] i_tile_lon;
    logic              i_load_ok;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [3:0]        o_status;
    logic              o_evict_valid;
    logic signed [7:0] o_evict_lat;
    logic signed [8:0] o_evict_lon;

    logic [2:0]     tile_state [0:TILE_COUNT-1];
    logic [15:0]    lru_order [0:MAX_RES-1];
    int             resident_cnt;
    t_tile_result   expected_results [$];
    int             error_count;
    int             idle_cycles;
    bit             steady;

    tile_residency_lru_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_tile_lat    (i_tile_lat),
        .i_tile_lon    (i_tile_lon),
        .i_load_ok     (i_load_ok),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_evict_valid (o_evict_valid),
        .o_evict_lat   (o_evict_lat),
        .o_evict_lon   (o_evict_lon)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Computes the result of one item and updates the tracked tile states and LRU order.
    task automatic predict_tile_result(input logic [1:0] fn, input logic signed [7:0] lat,
                                       input logic signed [8:0] lon, input logic ok,
                                       output t_tile_result res);
        int la;
        int lo;
        int idx;
        int pos;
        int victim;
        logic [2:0] ts;
        la = lat;
        lo = lon;
        res = '0;
        res.status = trlt_pkg::ST_IGNORED;
        if (fn != trlt_pkg::FN_UNUSED && la >= -90 && la <= 89 && lo >= -180 && lo <= 179)
        begin
            idx = (la + 90) * 360 + (lo + 180);
            ts = tile_state[idx];
            if (fn == trlt_pkg::FN_DECLARE) begin
                if (ts == trlt_pkg::TS_UNKNOWN) begin
                    tile_state[idx] = trlt_pkg::TS_IDLE;
                end
                res.status = trlt_pkg::ST_DECLARED;
            end else if (fn == trlt_pkg::FN_QUERY) begin
                case (ts)
                    trlt_pkg::TS_RESIDENT: begin
                        pos = 0;
                        while (pos < resident_cnt && lru_order[pos] != 16'(idx)) begin
                            pos++;
                        end
                        if (pos < resident_cnt) begin
                            for (int i = pos; i > 0; i--) begin
                                lru_order[i] = lru_order[i-1];
                            end
                            lru_order[0] = 16'(idx);
                        end
                        res.status = trlt_pkg::ST_HIT;
                    end
                    trlt_pkg::TS_FAILED: begin
                        res.status = trlt_pkg::ST_FAILED;
                    end
                    trlt_pkg::TS_IDLE: begin
                        tile_state[idx] = trlt_pkg::TS_PENDING;
                        res.status = trlt_pkg::ST_REQUESTED;
                    end
                    trlt_pkg::TS_PENDING: begin
                        res.status = trlt_pkg::ST_PENDING;
                    end
                    default: begin
                        res.status = trlt_pkg::ST_ABSENT;
                    end
                endcase
            end else if (ts == trlt_pkg::TS_PENDING) begin
                if (!ok) begin
                    tile_state[idx] = trlt_pkg::TS_FAILED;
                    res.status = trlt_pkg::ST_FAIL_REC;
                end else begin
                    if (resident_cnt >= MAX_RES) begin
                        victim = lru_order[MAX_RES-1];
                        resident_cnt = MAX_RES - 1;
                        tile_state[victim] = trlt_pkg::TS_IDLE;
                        res.ev_valid = 1'b1;
                        res.ev_lat = 8'(victim / 360 - 90);
                        res.ev_lon = 9'(victim % 360 - 180);
                    end
                    for (int i = resident_cnt; i > 0; i--) begin
                        lru_order[i] = lru_order[i-1];
                    end
                    lru_order[0] = 16'(idx);
                    resident_cnt++;
                    tile_state[idx] = trlt_pkg::TS_RESIDENT;
                    res.status = trlt_pkg::ST_INSTALLED;
                end
            end
        end
    endtask

    task automatic send_tile_item(input logic [1:0] fn, input int lat, input int lon,
                                  input logic ok, output logic [3:0] status);
        int gap;
        t_tile_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_tile_lat <= 8'(lat);
        i_tile_lon <= 9'(lon);
        i_load_ok  <= ok;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tile_result(fn, 8'(lat), 9'(lon), ok, res);
        expected_results.insert(expected_results.size(), res);
        status = res.status;
    endtask

    task automatic test_directed();
        logic [3:0] st;
        send_tile_item(trlt_pkg::FN_QUERY, -90, -180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_DECLARE, -90, -180, 1'b0, st);
        send_tile_item(trlt_pkg::FN_DECLARE, -90, -180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, -90, -180, 1'b0, st);
        send_tile_item(trlt_pkg::FN_QUERY, -90, -180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, -90, -180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, -90, -180, 1'b0, st);
        send_tile_item(trlt_pkg::FN_DECLARE, -90, -180, 1'b0, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, -90, -180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_DECLARE, 89, 179, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, 89, 179, 1'b1, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, 89, 179, 1'b0, st);
        send_tile_item(trlt_pkg::FN_QUERY, 89, 179, 1'b0, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, 89, 179, 1'b1, st);
        send_tile_item(trlt_pkg::FN_DECLARE, 89, 179, 1'b0, st);
        send_tile_item(trlt_pkg::FN_UNUSED, 0, 0, 1'b1, st);
        send_tile_item(trlt_pkg::FN_DECLARE, 90, 0, 1'b0, st);
        send_tile_item(trlt_pkg::FN_QUERY, -91, 0, 1'b0, st);
        send_tile_item(trlt_pkg::FN_DECLARE, 0, 180, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, 0, -181, 1'b0, st);
        send_tile_item(trlt_pkg::FN_DECLARE, 127, 255, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, -128, -256, 1'b0, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, 5, 5, 1'b1, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, -128, 255, 1'b1, st);
    endtask

    // Fills the resident list past capacity with no idle cycles on either side.
    task automatic test_eviction();
        logic [3:0] st;
        steady = 1'b1;
        for (int k = 0; k < MAX_RES + 2; k++) begin
            send_tile_item(trlt_pkg::FN_DECLARE, 10 + k, -5 * k, 1'b0, st);
            send_tile_item(trlt_pkg::FN_QUERY, 10 + k, -5 * k, 1'b0, st);
            send_tile_item(trlt_pkg::FN_COMPLETE, 10 + k, -5 * k, 1'b1, st);
        end
        send_tile_item(trlt_pkg::FN_QUERY, 13, -15, 1'b0, st);
        send_tile_item(trlt_pkg::FN_QUERY, 10, 0, 1'b0, st);
        send_tile_item(trlt_pkg::FN_COMPLETE, 10, 0, 1'b1, st);
        send_tile_item(trlt_pkg::FN_QUERY, 13, -15, 1'b0, st);
        steady = 1'b0;
    endtask

    // Mostly well-formed declare, query and completion sequences over a small pool of
    // tiles, so that the resident list overflows often, mixed with raw noise.
    task automatic test_random();
        int pool_lat [POOL_SIZE];
        int pool_lon [POOL_SIZE];
        int sent;
        int k;
        int r;
        int lat;
        int lon;
        logic [1:0] fn;
        logic ok;
        logic [2:0] ts;
        logic [3:0] st;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_lat[i] = $urandom_range(0, 179) - 90;
            pool_lon[i] = $urandom_range(0, 359) - 180;
        end
        sent = 0;
        while (sent < RANDOM_TARGET) begin
            steady = (sent % 300) >= 250;
            r = $urandom_range(0, 99);
            ok = 1'($urandom_range(0, 1));
            if (r < 80) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                lat = pool_lat[k];
                lon = pool_lon[k];
                ts = tile_state[(lat + 90) * 360 + (lon + 180)];
                case (ts)
                    trlt_pkg::TS_UNKNOWN: begin
                        fn = trlt_pkg::FN_DECLARE;
                    end
                    trlt_pkg::TS_IDLE: begin
                        fn = ($urandom_range(0, 7) == 0) ? trlt_pkg::FN_DECLARE
                                                         : trlt_pkg::FN_QUERY;
                    end
                    trlt_pkg::TS_PENDING: begin
                        fn = ($urandom_range(0, 5) == 0) ? trlt_pkg::FN_QUERY
                                                         : trlt_pkg::FN_COMPLETE;
                        ok = $urandom_range(0, 99) < 85;
                    end
                    trlt_pkg::TS_RESIDENT: begin
                        fn = trlt_pkg::FN_QUERY;
                        if ($urandom_range(0, 4) == 0) begin
                            fn = $urandom_range(0, 1) ? trlt_pkg::FN_COMPLETE
                                                      : trlt_pkg::FN_DECLARE;
                        end
                    end
                    default: begin
                        fn = trlt_pkg::FN_QUERY;
                        if ($urandom_range(0, 1) == 1) begin
                            pool_lat[k] = $urandom_range(0, 179) - 90;
                            pool_lon[k] = $urandom_range(0, 359) - 180;
                        end
                    end
                endcase
            end else if (r < 90) begin
                fn = 2'($urandom_range(0, 3));
                lat = $urandom_range(0, 255);
                lon = $urandom_range(0, 511);
            end else begin
                fn = 2'($urandom_range(0, 2));
                lat = $urandom_range(0, 179) - 90;
                lon = $urandom_range(0, 359) - 180;
            end
            send_tile_item(fn, lat, lon, ok, st);
            sent++;
        end
        steady = 1'b0;
    endtask

    initial begin
        steady = 1'b0;
        error_count = 0;
        resident_cnt = 0;
        for (int i = 0; i < TILE_COUNT; i++) begin
            tile_state[i] = trlt_pkg::TS_UNKNOWN;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            lru_order[i] = '0;
        end
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_func     <= trlt_pkg::FN_DECLARE;
        i_tile_lat <= '0;
        i_tile_lon <= '0;
        i_load_ok  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_eviction();
        test_random();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        int run;
        int gap;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            run = steady ? 8 : $urandom_range(1, 12);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_tile_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no item pending: status %0d evict %0b %0d %0d",
                             $realtime, o_status, o_evict_valid, o_evict_lat, o_evict_lon);
                end
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (o_status !== want.status || o_evict_valid !== want.ev_valid ||
                    o_evict_lat !== want.ev_lat || o_evict_lon !== want.ev_lon) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: expected status %0d evict %0b %0d %0d, got %0d %0b %0d %0d",
                                 $realtime, want.status, want.ev_valid, want.ev_lat,
                                 want.ev_lon, o_status, o_evict_valid, o_evict_lat,
                                 o_evict_lon);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
